// ----- sv/hid_boot_keyboard_event_decoder_top_assert.svh -----
// ----------------------------------------------------------------------------
// hkd assertion macros
// same-cycle and next-cycle concurrent implication checks, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef HID_BOOT_KEYBOARD_EVENT_DECODER_TOP_ASSERT_SVH
`define HID_BOOT_KEYBOARD_EVENT_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HKD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define HKD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HKD_ASSERT_IMP(lbl, ante, cons, msg)
`define HKD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/hkd_pkg.sv -----
// ----------------------------------------------------------------------------
// hkd_pkg
// shared types, usage codes and modifier mapping of the boot keyboard decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hkd_pkg;

   localparam int NUM_SLOTS = 6;
   localparam int NUM_MODS  = 8;
   localparam int NUM_CAND  = NUM_MODS + NUM_SLOTS;

   localparam logic [7:0] USAGE_NONE     = 8'h00;
   localparam logic [7:0] USAGE_ROLLOVER = 8'h01;
   localparam logic [7:0] USAGE_CAPSLOCK = 8'h39;
   localparam logic [7:0] USAGE_MOD_BASE = 8'hE0;
   localparam logic [7:0] USAGE_LCTRL    = 8'hE0;
   localparam logic [7:0] USAGE_LSHIFT   = 8'hE1;
   localparam logic [7:0] USAGE_LALT     = 8'hE2;
   localparam logic [7:0] USAGE_RCTRL    = 8'hE4;
   localparam logic [7:0] USAGE_RSHIFT   = 8'hE5;
   localparam logic [7:0] USAGE_RALT     = 8'hE6;

   localparam logic [6:0] MASK_LSHIFT = 7'h01;
   localparam logic [6:0] MASK_RSHIFT = 7'h02;
   localparam logic [6:0] MASK_LALT   = 7'h04;
   localparam logic [6:0] MASK_RALT   = 7'h08;
   localparam logic [6:0] MASK_LCTRL  = 7'h10;
   localparam logic [6:0] MASK_RCTRL  = 7'h20;
   localparam logic [6:0] MASK_CAPS   = 7'h40;
   localparam int         MOD_CAPS_BIT = 6;

   localparam logic ITEM_EVENT   = 1'b0;
   localparam logic ITEM_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT
   } hkd_state_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic emit_evt;
      logic emit_sum;
   } hkd_cmd_type;

   typedef struct packed {
      logic pend_any;
      logic rollover;
      logic out_free;
   } hkd_status_type;

   typedef struct packed {
      logic [7:0]                modifier_bits;
      logic [NUM_SLOTS-1:0][7:0] key_slot;
   } hkd_report_type;

   function automatic logic [6:0] mod_mask_of(input logic [7:0] usage);
      logic [6:0] mask;
      case (usage)
         USAGE_LSHIFT: mask = MASK_LSHIFT;
         USAGE_RSHIFT: mask = MASK_RSHIFT;
         USAGE_LALT:   mask = MASK_LALT;
         USAGE_RALT:   mask = MASK_RALT;
         USAGE_LCTRL:  mask = MASK_LCTRL;
         USAGE_RCTRL:  mask = MASK_RCTRL;
         default:      mask = '0;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

// ----- sv/hkd_if.sv -----
// ----------------------------------------------------------------------------
// hkd channel interfaces
// report input and decoded item output, valid/ready transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface hkd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifier_bits;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;

   modport source (
      output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5,
      input  ready
   );
   modport sink (
      input  valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
             key_slot_3, key_slot_4, key_slot_5,
      output ready
   );
endinterface

interface hkd_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] key_usage;
   logic [6:0] modifier_state;
   logic       led_write;
   logic       caps_led_on;
   logic       repeat_arm;
   logic       rollover_error;
   logic       last_item;

   modport source (
      output valid, item_kind, key_usage, modifier_state, led_write,
             caps_led_on, repeat_arm, rollover_error, last_item,
      input  ready
   );
   modport sink (
      input  valid, item_kind, key_usage, modifier_state, led_write,
             caps_led_on, repeat_arm, rollover_error, last_item,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/hkd_ctrl.sv -----
// ----------------------------------------------------------------------------
// hkd_ctrl
// sequencer: load, eval, one event per cycle when output free, then summary
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_boot_keyboard_event_decoder_top_assert.svh"

module hkd_ctrl
   import hkd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire hkd_status_type status_i,
   output hkd_cmd_type         cmd_o
);

   hkd_state_type state_ff;
   hkd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status_i.out_free && (status_i.rollover || !status_i.pend_any)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd_o     = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd_o.load = req_valid;
         end
         ST_EVAL: begin
            cmd_o.eval = 1'b1;
         end
         ST_EMIT: begin
            if (status_i.out_free) begin
               if (status_i.rollover || !status_i.pend_any) begin
                  cmd_o.emit_sum = 1'b1;
               end else begin
                  cmd_o.emit_evt = 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   `HKD_ASSERT_NXT(a_accept_goes_eval, req_valid && req_ready, state_ff == ST_EVAL, "accepted transaction not evaluated")
   `HKD_ASSERT_NXT(a_summary_ends_report, cmd_o.emit_sum, state_ff == ST_IDLE, "summary did not end the report")

endmodule

`default_nettype wire

// ----- sv/hkd_dpath.sv -----
// ----------------------------------------------------------------------------
// hkd_dpath
// report registers, press and release compare, modifier word, output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "hid_boot_keyboard_event_decoder_top_assert.svh"

module hkd_dpath
   import hkd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire hkd_report_type report_i,
   input  wire hkd_cmd_type    cmd_i,
   output hkd_status_type      status_o,
   hkd_rsp_if.source           rsp_bus
);

   hkd_report_type      cur_ff, cur_in;
   hkd_report_type      prev_ff, prev_in;
   logic [NUM_CAND-1:0] pend_ff, pend_in;
   logic [6:0]          modword_ff, modword_in;
   logic [6:0]          relmask_ff, relmask_in;
   logic                relany_ff, relany_in;
   logic                pressany_ff, pressany_in;
   logic                roll_ff, roll_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_kind_ff, out_kind_in;
   logic [7:0]          out_usage_ff, out_usage_in;
   logic [6:0]          out_mods_ff, out_mods_in;
   logic                out_led_ff, out_led_in;
   logic                out_rep_ff, out_rep_in;
   logic                out_roll_ff, out_roll_in;

   logic [NUM_CAND-1:0][7:0] cand_val;
   logic [NUM_CAND-1:0]      cand_vld;
   logic [NUM_CAND-1:0][7:0] prev_val;
   logic [NUM_CAND-1:0]      prev_vld;
   logic [NUM_CAND-1:0]      sel;
   logic [7:0]               sel_usage;
   logic [6:0]               evt_word;
   logic                     evt_led;
   logic                     out_free;

   function automatic logic set_has(input hkd_report_type rpt, input logic [7:0] usage);
      logic hit;
      hit = (usage[7:3] == USAGE_MOD_BASE[7:3]) && rpt.modifier_bits[usage[2:0]];
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if ((rpt.key_slot[i] == usage) && (usage != USAGE_NONE)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // candidate usages of the current and the held report
   always_comb begin
      for (int k = 0; k < NUM_MODS; k++) begin
         cand_val[k] = {USAGE_MOD_BASE[7:3], 3'(k)};
         cand_vld[k] = cur_ff.modifier_bits[k];
         prev_val[k] = {USAGE_MOD_BASE[7:3], 3'(k)};
         prev_vld[k] = prev_ff.modifier_bits[k];
      end
      for (int k = 0; k < NUM_SLOTS; k++) begin
         cand_val[NUM_MODS+k] = cur_ff.key_slot[k];
         cand_vld[NUM_MODS+k] = cur_ff.key_slot[k] != USAGE_NONE;
         prev_val[NUM_MODS+k] = prev_ff.key_slot[k];
         prev_vld[NUM_MODS+k] = prev_ff.key_slot[k] != USAGE_NONE;
      end
   end

   // lowest pending usage, duplicates selected together
   always_comb begin
      sel_usage = '0;
      for (int k = 0; k < NUM_CAND; k++) begin
         sel[k] = pend_ff[k];
         for (int j = 0; j < NUM_CAND; j++) begin
            if (pend_ff[j] && (cand_val[j] < cand_val[k])) begin
               sel[k] = 1'b0;
            end
         end
         if (sel[k]) begin
            sel_usage = sel_usage | cand_val[k];
         end
      end
      evt_led  = sel_usage == USAGE_CAPSLOCK;
      evt_word = modword_ff | mod_mask_of(sel_usage);
      if (evt_led) begin
         evt_word = evt_word ^ MASK_CAPS;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      status_o.pend_any = |pend_ff;
      status_o.rollover = roll_ff;
      status_o.out_free = out_free;
   end

   always_comb begin
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      pend_in      = pend_ff;
      modword_in   = modword_ff;
      relmask_in   = relmask_ff;
      relany_in    = relany_ff;
      pressany_in  = pressany_ff;
      roll_in      = roll_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      out_kind_in  = out_kind_ff;
      out_usage_in = out_usage_ff;
      out_mods_in  = out_mods_ff;
      out_led_in   = out_led_ff;
      out_rep_in   = out_rep_ff;
      out_roll_in  = out_roll_ff;

      if (cmd_i.load) begin
         cur_in = report_i;
      end

      if (cmd_i.eval) begin
         relmask_in = '0;
         relany_in  = 1'b0;
         for (int k = 0; k < NUM_CAND; k++) begin
            pend_in[k] = cand_vld[k] && !set_has(prev_ff, cand_val[k]);
            if (prev_vld[k] && !set_has(cur_ff, prev_val[k])) begin
               relany_in  = 1'b1;
               relmask_in = relmask_in | mod_mask_of(prev_val[k]);
            end
         end
         pressany_in = |pend_in;
         roll_in     = set_has(cur_ff, USAGE_ROLLOVER) && !set_has(prev_ff, USAGE_ROLLOVER);
      end

      if (cmd_i.emit_evt) begin
         pend_in      = pend_ff & ~sel;
         modword_in   = evt_word;
         rsp_valid_in = 1'b1;
         out_kind_in  = ITEM_EVENT;
         out_usage_in = sel_usage;
         out_mods_in  = evt_word;
         out_led_in   = evt_led;
         out_rep_in   = 1'b0;
         out_roll_in  = 1'b0;
      end

      if (cmd_i.emit_sum) begin
         rsp_valid_in = 1'b1;
         out_kind_in  = ITEM_SUMMARY;
         out_usage_in = USAGE_NONE;
         out_led_in   = 1'b0;
         out_roll_in  = roll_ff;
         pend_in      = '0;
         if (roll_ff) begin
            out_mods_in = modword_ff;
            out_rep_in  = 1'b0;
         end else begin
            modword_in  = modword_ff & ~relmask_ff;
            out_mods_in = modword_ff & ~relmask_ff;
            out_rep_in  = pressany_ff && !relany_ff;
            prev_in     = cur_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         modword_ff   <= '0;
         pend_ff      <= '0;
         roll_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         modword_ff   <= modword_in;
         pend_ff      <= pend_in;
         roll_ff      <= roll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      relmask_ff   <= relmask_in;
      relany_ff    <= relany_in;
      pressany_ff  <= pressany_in;
      out_kind_ff  <= out_kind_in;
      out_usage_ff <= out_usage_in;
      out_mods_ff  <= out_mods_in;
      out_led_ff   <= out_led_in;
      out_rep_ff   <= out_rep_in;
      out_roll_ff  <= out_roll_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.item_kind      = out_kind_ff;
   assign rsp_bus.key_usage      = out_usage_ff;
   assign rsp_bus.modifier_state = out_mods_ff;
   assign rsp_bus.led_write      = out_led_ff;
   assign rsp_bus.caps_led_on    = out_mods_ff[MOD_CAPS_BIT];
   assign rsp_bus.repeat_arm     = out_rep_ff;
   assign rsp_bus.rollover_error = out_roll_ff;
   assign rsp_bus.last_item      = out_kind_ff == ITEM_SUMMARY;

   `HKD_ASSERT_IMP(a_evt_has_pending, cmd_i.emit_evt, (|pend_ff) && out_free && !roll_ff, "event issued with nothing pending")
   `HKD_ASSERT_IMP(a_led_only_caps, rsp_valid_ff && out_led_ff, (out_kind_ff == ITEM_EVENT) && (out_usage_ff == USAGE_CAPSLOCK), "led write on a non caps lock item")
   `HKD_ASSERT_IMP(a_rollover_clean, rsp_valid_ff && out_roll_ff, (out_kind_ff == ITEM_SUMMARY) && !out_rep_ff, "rollover item not a plain summary")

endmodule

`default_nettype wire

// ----- sv/hid_boot_keyboard_event_decoder_top.sv -----
// a report is loaded and evaluated, then items leave one per cycle unless the output stalls
// a report gives its key press events, none on rollover, plus one summary item
// the press loop emits one usage per cycle unless stalled, from a shared lowest-usage selector
// a new report is taken once the summary sits in the output register
// reset (synchronous, active high) clears the held report and modifier word
// ----------------------------------------------------------------------------
// hid_boot_keyboard_event_decoder_top
// boot keyboard report decoder: press events in usage order plus a summary
// ----------------------------------------------------------------------------
`default_nettype none

module hid_boot_keyboard_event_decoder_top
   import hkd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   hkd_req_if.sink   req_bus,
   hkd_rsp_if.source rsp_bus
);

   hkd_cmd_type    cmd;
   hkd_status_type status;
   hkd_report_type report;
   logic           req_ready;

   always_comb begin
      report.modifier_bits = req_bus.modifier_bits;
      report.key_slot[0]   = req_bus.key_slot_0;
      report.key_slot[1]   = req_bus.key_slot_1;
      report.key_slot[2]   = req_bus.key_slot_2;
      report.key_slot[3]   = req_bus.key_slot_3;
      report.key_slot[4]   = req_bus.key_slot_4;
      report.key_slot[5]   = req_bus.key_slot_5;
   end

   assign req_bus.ready = req_ready;

   hkd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   hkd_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .report_i (report),
      .cmd_i    (cmd),
      .status_o (status),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire
